### design/tile_text_layer_pixel_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tile/text pixel compositor
// Shared concurrent-assertion wrappers, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef TILE_TEXT_LAYER_PIXEL_ASSERT_SVH
`define TILE_TEXT_LAYER_PIXEL_ASSERT_SVH

// same-cycle implication
`define TTL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ttl_pkg.sv
// ----------------------------------------------------------------------------
// ttl_pkg
// Types, codes and decode functions of the tile/text pixel compositor.
// ----------------------------------------------------------------------------
package ttl_pkg;

   // memory geometry
   localparam int MAP_DEPTH  = 4096;
   localparam int TILE_DEPTH = 4096;
   localparam int CHAR_DEPTH = 1024;
   localparam int LUT_DEPTH  = 256;
   localparam int TEXT_DEPTH = 1024;
   localparam int MAP_AW     = $clog2(MAP_DEPTH);
   localparam int TILE_AW    = $clog2(TILE_DEPTH);
   localparam int CHAR_AW    = $clog2(CHAR_DEPTH);
   localparam int LUT_AW     = $clog2(LUT_DEPTH);
   localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
   localparam int BYTE_W     = 8;
   localparam int COLOR_W    = 4;

   // port widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 2;

   // function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // memory select codes
   localparam logic [2:0] MEM_MAP  = 3'd0;
   localparam logic [2:0] MEM_TILE = 3'd1;
   localparam logic [2:0] MEM_CHAR = 3'd2;
   localparam logic [2:0] MEM_LUT  = 3'd3;
   localparam logic [2:0] MEM_TEXT = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MAP_SCREEN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GROUND_BANK = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TEXT_DIRECT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GROUND_OFF  = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CODE,
      ST_BITS,
      ST_LOOK
   } ttl_state_type;

   typedef struct packed {
      logic [1:0] map_screen;
      logic [1:0] ground_bank;
      logic       text_direct;
      logic       ground_disable;
   } ttl_cfg_type;

   // read and write requests toward the five memories
   typedef struct packed {
      logic                map_re;
      logic [MAP_AW-1:0]   map_raddr;
      logic                text_re;
      logic [TEXT_AW-1:0]  text_raddr;
      logic                tile_re;
      logic [TILE_AW-1:0]  tile_raddr;
      logic                char_re;
      logic [CHAR_AW-1:0]  char_raddr;
      logic                lut_re;
      logic [LUT_AW-1:0]   lut_raddr;
      logic                map_we;
      logic                tile_we;
      logic                char_we;
      logic                lut_we;
      logic                text_we;
      logic [MAP_AW-1:0]   waddr;
      logic [BYTE_W-1:0]   wdata;
   } ttl_mem_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  map_rdata;
      logic [BYTE_W-1:0]  text_rdata;
      logic [BYTE_W-1:0]  tile_rdata;
      logic [BYTE_W-1:0]  char_rdata;
      logic [COLOR_W-1:0] lut_rdata;
   } ttl_mem_rsp_type;

   // visible cell to 32x32 store address, screen columns run rotated
   function automatic logic [TEXT_AW-1:0] cell_address(input logic [5:0] column,
                                                       input logic [4:0] row);
      logic [5:0]  c;
      logic [5:0]  r;
      logic [10:0] sum;
      c = column - 6'd2;
      r = {1'b0, row} + 6'd2;
      if (c[5]) begin
         sum = {5'd0, r} + {1'b0, c[4:0], 5'd0};
      end else begin
         sum = {5'd0, c} + {r, 5'd0};
      end
      return sum[TEXT_AW-1:0];
   endfunction

   // text colour from the text code
   function automatic logic [COLOR_W-1:0] text_color(input logic [BYTE_W-1:0] code,
                                                     input logic direct);
      logic [COLOR_W-1:0] remap;
      remap = {code[7], code[6], code[5] | code[4], 1'b0};
      return direct ? code[3:0] : remap;
   endfunction

   // 2-bit background pixel from one tile byte; both halves share the nibble split
   function automatic logic [1:0] ground_pixel(input logic [BYTE_W-1:0] tile_byte,
                                               input logic [1:0] x_low);
      logic [2:0] hi_sel;
      logic [2:0] lo_sel;
      hi_sel = {1'b1, ~x_low};
      lo_sel = {1'b0, ~x_low};
      return {tile_byte[hi_sel], tile_byte[lo_sel]};
   endfunction

endpackage

### design/ttl_ram.sv
// ----------------------------------------------------------------------------
// ttl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ttl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/ttl_render.sv
// ----------------------------------------------------------------------------
// ttl_render
// Sequencer of the compositor: memory writes, the three dependent read
// steps of a pixel, compositing and the result register.
// ----------------------------------------------------------------------------
`include "tile_text_layer_pixel_assert.svh"

module ttl_render (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_func,
   input  logic [2:0]                req_mem_select,
   input  logic [11:0]               req_mem_address,
   input  logic [7:0]                req_mem_data,
   input  logic [5:0]                req_cell_column,
   input  logic [4:0]                req_cell_row,
   input  logic [2:0]                req_pixel_x,
   input  logic [2:0]                req_pixel_y,
   input  ttl_pkg::ttl_cfg_type      cfg,
   output ttl_pkg::ttl_mem_req_type  mem_req,
   input  ttl_pkg::ttl_mem_rsp_type  mem_rsp,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [3:0]                rsp_color_index
);

   ttl_pkg::ttl_state_type state_ff, state_in;

   logic [2:0] px_ff, px_in;
   logic [2:0] py_ff, py_in;
   logic [3:0] mnib_ff, mnib_in;
   logic [3:0] tcolor_ff, tcolor_in;
   logic       tset_ff, tset_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_data_ff, rsp_data_in;

   logic                          req_fire;
   logic                          rsp_load;
   logic [ttl_pkg::TEXT_AW-1:0]   cell_addr;
   logic [3:0]                    ground_nib;
   logic [1:0]                    gpix;

   assign req_fire  = req_tvalid && req_tready;
   assign cell_addr = ttl_pkg::cell_address(req_cell_column, req_cell_row);
   assign ground_nib = cfg.ground_disable ? 4'hF : mnib_ff;
   assign gpix      = ttl_pkg::ground_pixel(mem_rsp.tile_rdata, px_ff[1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttl_pkg::ST_IDLE: begin
            if (req_fire && (req_func == ttl_pkg::FUNC_PIXEL)) begin
               state_in = ttl_pkg::ST_CODE;
            end
         end
         ttl_pkg::ST_CODE: begin
            state_in = ttl_pkg::ST_BITS;
         end
         ttl_pkg::ST_BITS: begin
            state_in = ttl_pkg::ST_LOOK;
         end
         ttl_pkg::ST_LOOK: begin
            if (rsp_load) begin
               state_in = ttl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ttl_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the state machine: handshake and memory requests
   always_comb begin
      req_tready         = 1'b0;
      rsp_load           = 1'b0;
      mem_req            = '0;
      mem_req.map_raddr  = {cfg.map_screen, cell_addr};
      mem_req.text_raddr = cell_addr;
      mem_req.tile_raddr = {mem_rsp.map_rdata, ~px_ff[2], py_ff};
      mem_req.char_raddr = {mem_rsp.text_rdata[6:0], py_ff};
      mem_req.lut_raddr  = {cfg.ground_bank, ground_nib, gpix};
      mem_req.waddr      = req_mem_address;
      mem_req.wdata      = req_mem_data;
      unique case (state_ff)
         ttl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_func == ttl_pkg::FUNC_PIXEL) begin
                  mem_req.map_re  = 1'b1;
                  mem_req.text_re = 1'b1;
               end else begin
                  case (req_mem_select)
                     ttl_pkg::MEM_MAP:  mem_req.map_we  = 1'b1;
                     ttl_pkg::MEM_TILE: mem_req.tile_we = 1'b1;
                     ttl_pkg::MEM_CHAR: mem_req.char_we = 1'b1;
                     ttl_pkg::MEM_LUT:  mem_req.lut_we  = 1'b1;
                     ttl_pkg::MEM_TEXT: mem_req.text_we = 1'b1;
                     default:           mem_req.map_we  = 1'b0;
                  endcase
               end
            end
         end
         ttl_pkg::ST_CODE: begin
            mem_req.tile_re = 1'b1;
            mem_req.char_re = 1'b1;
         end
         ttl_pkg::ST_BITS: begin
            mem_req.lut_re = 1'b1;
         end
         ttl_pkg::ST_LOOK: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      px_in        = px_ff;
      py_in        = py_ff;
      mnib_in      = mnib_ff;
      tcolor_in    = tcolor_ff;
      tset_in      = tset_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_fire) begin
         px_in = req_pixel_x;
         py_in = req_pixel_y;
      end
      if (state_ff == ttl_pkg::ST_CODE) begin
         mnib_in   = mem_rsp.map_rdata[7:4];
         tcolor_in = ttl_pkg::text_color(mem_rsp.text_rdata, cfg.text_direct);
      end
      if (state_ff == ttl_pkg::ST_BITS) begin
         tset_in = mem_rsp.char_rdata[px_ff];
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = tset_ff ? tcolor_ff : mem_rsp.lut_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      mnib_ff     <= mnib_in;
      tcolor_ff   <= tcolor_in;
      tset_ff     <= tset_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_color_index = rsp_data_ff;

   // checks
   `TTL_ASSERT_NXT(a_pixel_starts, clock, reset,
      req_fire && (req_func == ttl_pkg::FUNC_PIXEL), state_ff == ttl_pkg::ST_CODE,
      "pixel transaction did not start the read sequence")
   `TTL_ASSERT_IMP(a_write_when_idle, clock, reset,
      mem_req.map_we || mem_req.tile_we || mem_req.char_we || mem_req.lut_we || mem_req.text_we,
      state_ff == ttl_pkg::ST_IDLE,
      "memory write issued while a pixel is in flight")
   `TTL_ASSERT_IMP(a_result_source, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == ttl_pkg::ST_LOOK,
      "result appeared outside the lookup step")
   `TTL_ASSERT_NXT(a_look_holds, clock, reset,
      (state_ff == ttl_pkg::ST_LOOK) && rsp_valid_ff && !rsp_tready,
      state_ff == ttl_pkg::ST_LOOK,
      "lookup step left while the result register was full")

endmodule

### design/tile_text_layer_pixel.sv
// ----------------------------------------------------------------------------
// tile_text_layer_pixel
// Background and text compositor: four byte memories, a 4-bit colour LUT,
// configuration registers and the render sequencer.
//
// Channel  Dir  Payload
// req_     in   tuser: func, mem_select; tdata: write address/data, cell, pixel
// rsp_     out  tdata: color_index
// csr_     in   csr_index, csr_data
//
// A memory write transaction is performed as it is accepted. A pixel
// transaction reads map code and text code, then tile and character
// bytes, then the colour lookup, as three dependent memory reads.
// Reset is synchronous and clears the sequencer state and the configuration
// registers; memory contents are undefined until written, with no clearing pass.
// A full result register holds the pixel in its last step until taken.
// ----------------------------------------------------------------------------
module tile_text_layer_pixel (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] func, [3:1] mem_select
   input  logic [ttl_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // [11:0] mem_address, [19:12] mem_data, [25:20] cell_column,
   // [30:26] cell_row, [33:31] pixel_x, [36:34] pixel_y, [39:37] zero
   input  logic [ttl_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [3:0] color_index, [7:4] zero
   output logic [ttl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ttl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ttl_pkg::CSR_DATA_W-1:0]    csr_data
);

   ttl_pkg::ttl_cfg_type     cfg_ff, cfg_in;
   ttl_pkg::ttl_mem_req_type mem_req;
   ttl_pkg::ttl_mem_rsp_type mem_rsp;
   logic [3:0]               color_index;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ttl_pkg::REG_MAP_SCREEN:  cfg_in.map_screen     = csr_data;
            ttl_pkg::REG_GROUND_BANK: cfg_in.ground_bank    = csr_data;
            ttl_pkg::REG_TEXT_DIRECT: cfg_in.text_direct    = csr_data[0];
            ttl_pkg::REG_GROUND_OFF:  cfg_in.ground_disable = csr_data[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   ttl_render u_render (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_func        (req_tuser[0]),
      .req_mem_select  (req_tuser[3:1]),
      .req_mem_address (req_tdata[11:0]),
      .req_mem_data    (req_tdata[19:12]),
      .req_cell_column (req_tdata[25:20]),
      .req_cell_row    (req_tdata[30:26]),
      .req_pixel_x     (req_tdata[33:31]),
      .req_pixel_y     (req_tdata[36:34]),
      .cfg             (cfg_ff),
      .mem_req         (mem_req),
      .mem_rsp         (mem_rsp),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_color_index (color_index)
   );

   assign rsp_tdata = {4'd0, color_index};

   // memories
   ttl_ram #(.WIDTH(ttl_pkg::BYTE_W), .DEPTH(ttl_pkg::MAP_DEPTH)) u_map_rom (
      .clock (clock),
      .we    (mem_req.map_we),
      .waddr (mem_req.waddr[ttl_pkg::MAP_AW-1:0]),
      .wdata (mem_req.wdata),
      .re    (mem_req.map_re),
      .raddr (mem_req.map_raddr),
      .rdata (mem_rsp.map_rdata)
   );

   ttl_ram #(.WIDTH(ttl_pkg::BYTE_W), .DEPTH(ttl_pkg::TILE_DEPTH)) u_tile_rom (
      .clock (clock),
      .we    (mem_req.tile_we),
      .waddr (mem_req.waddr[ttl_pkg::TILE_AW-1:0]),
      .wdata (mem_req.wdata),
      .re    (mem_req.tile_re),
      .raddr (mem_req.tile_raddr),
      .rdata (mem_rsp.tile_rdata)
   );

   ttl_ram #(.WIDTH(ttl_pkg::BYTE_W), .DEPTH(ttl_pkg::CHAR_DEPTH)) u_char_rom (
      .clock (clock),
      .we    (mem_req.char_we),
      .waddr (mem_req.waddr[ttl_pkg::CHAR_AW-1:0]),
      .wdata (mem_req.wdata),
      .re    (mem_req.char_re),
      .raddr (mem_req.char_raddr),
      .rdata (mem_rsp.char_rdata)
   );

   ttl_ram #(.WIDTH(ttl_pkg::COLOR_W), .DEPTH(ttl_pkg::LUT_DEPTH)) u_color_lut (
      .clock (clock),
      .we    (mem_req.lut_we),
      .waddr (mem_req.waddr[ttl_pkg::LUT_AW-1:0]),
      .wdata (mem_req.wdata[ttl_pkg::COLOR_W-1:0]),
      .re    (mem_req.lut_re),
      .raddr (mem_req.lut_raddr),
      .rdata (mem_rsp.lut_rdata)
   );

   ttl_ram #(.WIDTH(ttl_pkg::BYTE_W), .DEPTH(ttl_pkg::TEXT_DEPTH)) u_text_ram (
      .clock (clock),
      .we    (mem_req.text_we),
      .waddr (mem_req.waddr[ttl_pkg::TEXT_AW-1:0]),
      .wdata (mem_req.wdata),
      .re    (mem_req.text_re),
      .raddr (mem_req.text_raddr),
      .rdata (mem_rsp.text_rdata)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tile/text pixel compositor. A built-in
// predictor tracks the five memories and the four registers. Before any
// pixel is rendered, the bench fills every memory entry that the pixel
// will read with random bytes. Each pixel's expected palette index is
// queued, and a sink process compares every rsp transaction against it.
// Both stream sides idle at random. One phase holds the output off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

   localparam int         SETTLE_CYCLES = 8;
   localparam int         STALL_LIMIT   = 3000;
   localparam int         TOTAL_ITEMS   = 950;
   localparam int         MAX_PRINTS    = 50;
   localparam logic [2:0] MEM_UNUSED_LO = ttl_pkg::MEM_TEXT + 3'd1;
   localparam logic [ttl_pkg::CSR_INDEX_W-1:0] REG_UNUSED_LO = ttl_pkg::REG_GROUND_OFF + 3'd1;
   localparam logic [ttl_pkg::CSR_INDEX_W-1:0] REG_UNUSED_HI = '1;

   typedef struct packed {
      logic       func;
      logic [2:0] mem_select;
      logic [11:0] mem_address;
      logic [7:0] mem_data;
      logic [5:0] cell_column;
      logic [4:0] cell_row;
      logic [2:0] pixel_x;
      logic [2:0] pixel_y;
   } pixel_req_type;

   typedef struct packed {
      logic [3:0] color;
      pixel_req_type item;
   } pixel_expect_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ttl_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic [ttl_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ttl_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ttl_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ttl_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // predictor state: memory images, written flags, registers
   logic [7:0]  map_mem  [ttl_pkg::MAP_DEPTH];
   logic [7:0]  tile_mem [ttl_pkg::TILE_DEPTH];
   logic [7:0]  char_mem [ttl_pkg::CHAR_DEPTH];
   logic [3:0]  lut_mem  [ttl_pkg::LUT_DEPTH];
   logic [7:0]  text_mem [ttl_pkg::TEXT_DEPTH];
   bit          map_ok   [ttl_pkg::MAP_DEPTH];
   bit          tile_ok  [ttl_pkg::TILE_DEPTH];
   bit          char_ok  [ttl_pkg::CHAR_DEPTH];
   bit          lut_ok   [ttl_pkg::LUT_DEPTH];
   bit          text_ok  [ttl_pkg::TEXT_DEPTH];
   ttl_pkg::ttl_cfg_type layer_cfg = '0;

   // entries read by the most recent fully traced pixel
   logic [2:0]  recent_mem [5];
   int          recent_at  [5];
   bit          have_recent = 1'b0;

   pixel_expect_type pending_colors[$];
   int               error_count = 0;
   int               items_sent = 0;
   bit               rush = 1'b0;
   int               hold_request = 0;

   tile_text_layer_pixel dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),   // [0] func, [3:1] mem_select
      .req_tdata  (req_tdata),   // [11:0] addr, [19:12] data, [25:20] column,
                                 // [30:26] row, [33:31] x, [36:34] y
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [3:0] color_index
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) begin
         $display("tb: mismatch: %s", msg);
      end
      error_count++;
   endtask

   // Walk the read chain of one pixel. Returns 1 with the first entry
   // still unwritten, else 0 with the composed palette index.
   function automatic bit trace_pixel(input pixel_req_type it, output logic [2:0] miss_sel,
                                      output int miss_idx, output logic [3:0] color);
      logic [5:0] c;
      int         r, a, xl;
      int         map_i, tile_i, text_i, char_i, lut_i;
      logic [7:0] mcode, tbyte, tcode;
      logic [3:0] nib, tcol;
      logic [1:0] gpix;
      miss_sel = ttl_pkg::MEM_MAP;
      miss_idx = 0;
      color = '0;
      // visible cell to 32x32 store address, rotated columns when c[5] set
      c = it.cell_column - 6'd2;
      r = int'(it.cell_row) + 2;
      a = (c[5] ? r + int'(c[4:0]) * 32 : int'(c) + r * 32) % ttl_pkg::TEXT_DEPTH;
      map_i = a + int'(layer_cfg.map_screen) * 1024;
      text_i = a;
      if (!map_ok[map_i]) begin
         miss_sel = ttl_pkg::MEM_MAP;
         miss_idx = map_i;
         return 1'b1;
      end
      mcode = map_mem[map_i];
      // left half of the cell lives in the upper eight bytes of the tile
      tile_i = int'(mcode) * 16 + (it.pixel_x < 3'd4 ? 8 : 0) + int'(it.pixel_y);
      if (!tile_ok[tile_i]) begin
         miss_sel = ttl_pkg::MEM_TILE;
         miss_idx = tile_i;
         return 1'b1;
      end
      tbyte = tile_mem[tile_i];
      xl = int'(it.pixel_x[1:0]);
      gpix = {tbyte[7 - xl], tbyte[3 - xl]};
      if (!text_ok[text_i]) begin
         miss_sel = ttl_pkg::MEM_TEXT;
         miss_idx = text_i;
         return 1'b1;
      end
      tcode = text_mem[text_i];
      char_i = int'(tcode[6:0]) * 8 + int'(it.pixel_y);
      if (!char_ok[char_i]) begin
         miss_sel = ttl_pkg::MEM_CHAR;
         miss_idx = char_i;
         return 1'b1;
      end
      nib = layer_cfg.ground_disable ? 4'hf : mcode[7:4];
      lut_i = (int'(layer_cfg.ground_bank) * 16 + int'(nib)) * 4 + int'(gpix);
      if (!lut_ok[lut_i]) begin
         miss_sel = ttl_pkg::MEM_LUT;
         miss_idx = lut_i;
         return 1'b1;
      end
      tcol = layer_cfg.text_direct ? tcode[3:0]
                                   : ({tcode[7:5], 1'b0} | {2'b00, tcode[4], 1'b0});
      color = char_mem[char_i][it.pixel_x] ? tcol : lut_mem[lut_i];
      recent_mem = '{ttl_pkg::MEM_MAP, ttl_pkg::MEM_TILE, ttl_pkg::MEM_TEXT,
                     ttl_pkg::MEM_CHAR, ttl_pkg::MEM_LUT};
      recent_at = '{map_i, tile_i, text_i, char_i, lut_i};
      have_recent = 1'b1;
      return 1'b0;
   endfunction

   // update the memory images, or queue the expected color of a pixel
   task automatic apply_item(input pixel_req_type it);
      logic [2:0] sel;
      int         idx;
      logic [3:0] color;
      if (it.func == ttl_pkg::FUNC_PIXEL) begin
         if (trace_pixel(it, sel, idx, color)) begin
            report_mismatch("pixel sent before its memory entries were written");
         end
         pending_colors.push_back('{color: color, item: it});
         return;
      end
      case (it.mem_select)
         ttl_pkg::MEM_MAP: begin
            map_mem[it.mem_address] = it.mem_data;
            map_ok[it.mem_address] = 1'b1;
         end
         ttl_pkg::MEM_TILE: begin
            tile_mem[it.mem_address] = it.mem_data;
            tile_ok[it.mem_address] = 1'b1;
         end
         ttl_pkg::MEM_CHAR: begin
            char_mem[it.mem_address[ttl_pkg::CHAR_AW-1:0]] = it.mem_data;
            char_ok[it.mem_address[ttl_pkg::CHAR_AW-1:0]] = 1'b1;
         end
         ttl_pkg::MEM_LUT: begin
            lut_mem[it.mem_address[ttl_pkg::LUT_AW-1:0]] = it.mem_data[3:0];
            lut_ok[it.mem_address[ttl_pkg::LUT_AW-1:0]] = 1'b1;
         end
         ttl_pkg::MEM_TEXT: begin
            text_mem[it.mem_address[ttl_pkg::TEXT_AW-1:0]] = it.mem_data;
            text_ok[it.mem_address[ttl_pkg::TEXT_AW-1:0]] = 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic pixel_req_type random_pixel();
      pixel_req_type it;
      it.func        = ttl_pkg::FUNC_PIXEL;
      it.mem_select  = 3'($urandom_range(0, 7));
      it.mem_address = 12'($urandom_range(0, 4095));
      it.mem_data    = 8'($urandom_range(0, 255));
      it.cell_column = 6'($urandom_range(0, 63));
      it.cell_row    = 5'($urandom_range(0, 31));
      it.pixel_x     = 3'($urandom_range(0, 7));
      it.pixel_y     = 3'($urandom_range(0, 7));
      return it;
   endfunction

   // memory index plus a random multiple of the depth, so the address wraps
   function automatic logic [11:0] aliased_address(input logic [2:0] sel, input int idx);
      int depth;
      case (sel)
         ttl_pkg::MEM_CHAR: depth = ttl_pkg::CHAR_DEPTH;
         ttl_pkg::MEM_TEXT: depth = ttl_pkg::TEXT_DEPTH;
         ttl_pkg::MEM_LUT:  depth = ttl_pkg::LUT_DEPTH;
         default:           depth = ttl_pkg::MAP_DEPTH;
      endcase
      return 12'(idx + depth * $urandom_range(0, ttl_pkg::MAP_DEPTH / depth - 1));
   endfunction

   // one req transaction; valid stays high when the next item follows at once
   task automatic send_item(input pixel_req_type it);
      int gap;
      gap = rush ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      apply_item(it);
      req_tuser  <= {it.mem_select, it.func};
      req_tdata  <= {3'b000, it.pixel_y, it.pixel_x, it.cell_row, it.cell_column,
                     it.mem_data, it.mem_address};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_byte(input logic [2:0] sel, input logic [11:0] addr,
                             input logic [7:0] data);
      pixel_req_type it;
      it = random_pixel();
      it.func        = ttl_pkg::FUNC_WRITE;
      it.mem_select  = sel;
      it.mem_address = addr;
      it.mem_data    = data;
      send_item(it);
   endtask

   // fill every unwritten entry this pixel will read
   task automatic prepare_cell(input pixel_req_type it);
      logic [2:0] sel;
      int         idx;
      logic [3:0] color;
      while (trace_pixel(it, sel, idx, color)) begin
         write_byte(sel, aliased_address(sel, idx), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic draw_pixel(input pixel_req_type it);
      prepare_cell(it);
      send_item(it);
   endtask

   // release the input, wait for all results, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [ttl_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [ttl_pkg::CSR_DATA_W-1:0] value);
      wait_drained();
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         ttl_pkg::REG_MAP_SCREEN:  layer_cfg.map_screen     = value;
         ttl_pkg::REG_GROUND_BANK: layer_cfg.ground_bank    = value;
         ttl_pkg::REG_TEXT_DIRECT: layer_cfg.text_direct    = value[0];
         ttl_pkg::REG_GROUND_OFF:  layer_cfg.ground_disable = value[0];
         default: ;
      endcase
   endtask

   // cells at the edges of the visible range and beyond; an unused select
   // aimed at the map entry that the pixel reads must leave it alone
   task automatic test_directed_cells();
      logic [5:0] cols [4] = '{6'd0, 6'd35, 6'd63, 6'd34};
      logic [4:0] rows [4] = '{5'd0, 5'd27, 5'd31, 5'd13};
      logic [2:0] xs   [4] = '{3'd0, 3'd7, 3'd3, 3'd4};
      logic [2:0] ys   [4] = '{3'd0, 3'd7, 3'd4, 3'd3};
      pixel_req_type it;
      for (int i = 0; i < 4; i++) begin
         it = random_pixel();
         it.cell_column = cols[i];
         it.cell_row    = rows[i];
         it.pixel_x     = xs[i];
         it.pixel_y     = ys[i];
         prepare_cell(it);
         write_byte(MEM_UNUSED_LO + 3'(i % 3), 12'(recent_at[0]),
                    8'($urandom_range(0, 255)));
         send_item(it);
      end
   endtask

   // register sweep, extremes included; upper data bit of the 1-bit
   // registers and indexes past the last register are dropped
   task automatic test_register_settings();
      logic [1:0] screen_raw [4] = '{2'd3, 2'd1, 2'd2, 2'd0};
      logic [1:0] bank_raw   [4] = '{2'd3, 2'd2, 2'd1, 2'd0};
      logic [1:0] direct_raw [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
      logic [1:0] off_raw    [4] = '{2'd3, 2'd1, 2'd2, 2'd0};
      for (int p = 0; p < 4; p++) begin
         write_register(ttl_pkg::REG_MAP_SCREEN, screen_raw[p]);
         write_register(ttl_pkg::REG_GROUND_BANK, bank_raw[p]);
         write_register(ttl_pkg::REG_TEXT_DIRECT, direct_raw[p]);
         write_register(ttl_pkg::REG_GROUND_OFF, off_raw[p]);
         if (p == 0) begin
            write_register(REG_UNUSED_LO, 2'd2);
            write_register(REG_UNUSED_HI, 2'd1);
         end
         rush = (p == 2);
         repeat (25) draw_pixel(random_pixel());
      end
      rush = 1'b0;
   endtask

   // hold the output off while back-to-back pixels keep arriving
   task automatic test_output_backpressure();
      pixel_req_type cells [24];
      foreach (cells[i]) begin
         cells[i] = random_pixel();
         prepare_cell(cells[i]);
      end
      wait_drained();
      hold_request = 400;
      rush = 1'b1;
      foreach (cells[i]) send_item(cells[i]);
      rush = 1'b0;
   endtask

   // mostly fill-then-render sequences, with overwrites of entries just
   // read, stray writes, unused selects and occasional register changes,
   // until the run reaches its item count
   task automatic test_random_traffic();
      int         start, pick, k, next_retune, next_pace;
      logic [2:0] sel;
      start = items_sent;
      next_retune = start + 80;
      next_pace = start + 50;
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= next_pace) begin
            rush = ($urandom_range(0, 3) == 0);
            next_pace = items_sent + 50;
         end
         if (items_sent >= next_retune) begin
            write_register(ttl_pkg::REG_MAP_SCREEN, 2'($urandom_range(0, 3)));
            write_register(ttl_pkg::REG_GROUND_BANK, 2'($urandom_range(0, 3)));
            write_register(ttl_pkg::REG_TEXT_DIRECT, 2'($urandom_range(0, 3)));
            write_register(ttl_pkg::REG_GROUND_OFF, 2'($urandom_range(0, 3)));
            next_retune = items_sent + 80;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60 || !have_recent) begin
            draw_pixel(random_pixel());
         end else if (pick < 75) begin
            k = $urandom_range(0, 4);
            write_byte(recent_mem[k], aliased_address(recent_mem[k], recent_at[k]),
                       8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            sel = 3'($urandom_range(int'(ttl_pkg::MEM_MAP), int'(ttl_pkg::MEM_TEXT)));
            write_byte(sel, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
         end else begin
            sel = MEM_UNUSED_LO + 3'($urandom_range(0, 2));
            write_byte(sel, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
         end
      end
      rush = 1'b0;
   endtask

   // result sink: checks each rsp transaction and paces rsp_tready
   initial begin : color_sink
      int               stall_left;
      int               hold_left;
      pixel_expect_type want;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_colors.size() == 0) begin
               report_mismatch($sformatf("result %0d with nothing expected", rsp_tdata[3:0]));
            end else begin
               want = pending_colors.pop_front();
               if (rsp_tdata[3:0] !== want.color) begin
                  report_mismatch($sformatf(
                     "color %0d, expected %0d (cell %0d,%0d pixel %0d,%0d)",
                     rsp_tdata[3:0], want.color, want.item.cell_column,
                     want.item.cell_row, want.item.pixel_x, want.item.pixel_y));
               end
            end
            stall_left = rush ? 0 : $urandom_range(0, 19);
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: too long without any transaction ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb: done, errors");
      $finish;
   end

   // test sequence
   initial begin : main
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cells();
      test_register_settings();
      test_output_backpressure();
      test_random_traffic();
      wait_drained();
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
